// ===== sv/nmr_pkg.sv =====
// Shared types, widths and constants for the normal map renormalize block.
`timescale 1ns / 1ps

package nmr_pkg;

    localparam int COMP_W = 8;
    localparam int Q_W    = 7;
    localparam int SQ_W   = 15;
    localparam int S_W    = 16;
    localparam int T_W    = 30;
    localparam int P_W    = 30;
    localparam int R_W    = 25;
    localparam int C_W    = 34;
    localparam int N_STEP = Q_W;
    localparam int N_LANE = 3;

    localparam logic [COMP_W-1:0] COMP_BIAS = 8'h80;
    localparam logic [COMP_W-1:0] UNIT_LEN  = 8'h7F;
    localparam logic [COMP_W-1:0] CHAN_MAX  = 8'hFF;
    localparam int                T_SCALE   = (2 * 127) * (2 * 127);

    typedef enum logic [1:0] {
        VIEW_PLAIN  = 2'd0,
        VIEW_NORMAL = 2'd1,
        VIEW_ALPHA  = 2'd2
    } t_view_mode;

    // Search state of one color component.
    typedef struct packed {
        logic [Q_W-1:0]        q;
        logic signed [R_W-1:0] r;
        logic [P_W-1:0]        p;
        logic [T_W-1:0]        t;
        logic                  neg;
    } t_lane;

endpackage

// ===== sv/normal_map_pixel_renormalize_top.sv =====
// Top level of the normal map pixel renormalize pipeline.
`timescale 1ns / 1ps

// Channel   Valid        Ready        Word
// input     i_valid      o_ready      i_pixel_word
// output    o_valid      i_ready      o_red_out, o_green_out, o_blue_out
// config    i_cfg_valid  o_cfg_ready  i_cfg_data
//
// One pixel enters per cycle unless the output stalls, and passes ten register stages: one squares
// the components, one forms the sum of squares and the scaled targets, seven resolve one rounding
// bit each, and the last is the output register.
// Reset clears the valid bits and sets the view mode to plain color.
// A full stage holds only while the stage after it holds, so an empty stage still takes a word.

module normal_map_pixel_renormalize_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_pixel_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);
    import nmr_pkg::*;

    t_view_mode             r_view_mode;

    logic                   r1_vld;
    logic [31:0]            r1_word;
    t_view_mode             r1_mode;
    logic [SQ_W-1:0]        r1_sq   [N_LANE];
    logic                   r1_neg  [N_LANE];

    logic                   r2_vld;
    logic [31:0]            r2_word;
    t_view_mode             r2_mode;
    logic [S_W-1:0]         r2_s;
    t_lane                  r2_lane [N_LANE];

    logic                   r_sv_vld  [N_STEP];
    logic [31:0]            r_sv_word [N_STEP];
    t_view_mode             r_sv_mode [N_STEP];
    logic [S_W-1:0]         r_sv_s    [N_STEP];
    t_lane                  w_lane    [N_STEP][N_LANE];

    logic                   r_out_vld;
    logic [COMP_W-1:0]      r_out_chan [N_LANE];
    logic [COMP_W-1:0]      n_out_chan [N_LANE];

    logic                   en1;
    logic                   en2;
    logic                   en_sv [N_STEP];
    logic                   en_out;

    logic [COMP_W-1:0]      in_byte [N_LANE];
    logic [COMP_W-1:0]      in_mag  [N_LANE];
    logic [2*COMP_W-1:0]    in_prod [N_LANE];
    logic [S_W-1:0]         s_sum;
    logic [T_W:0]           t_prod  [N_LANE];

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_mode <= VIEW_PLAIN;
        end else if (i_cfg_valid) begin
            r_view_mode <= t_view_mode'(i_cfg_data);
        end
    end

    // Stage enables
    always_comb begin
        en_out = !r_out_vld || i_ready;
        en_sv[N_STEP-1] = !r_sv_vld[N_STEP-1] || en_out;
        for (int k = N_STEP - 2; k >= 0; k--) begin
            en_sv[k] = !r_sv_vld[k] || en_sv[k+1];
        end
        en2 = !r2_vld || en_sv[0];
        en1 = !r1_vld || en2;
    end

    assign o_ready = en1;

    // Stage 1: component magnitudes and squares
    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            in_byte[l] = i_pixel_word[8*(N_LANE-1-l) +: 8];
            in_mag[l]  = in_byte[l][7] ? {1'b0, in_byte[l][6:0]}
                                       : COMP_W'(9'd128 - {1'b0, in_byte[l]});
            in_prod[l] = {8'b0, in_mag[l]} * {8'b0, in_mag[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en1) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_word <= i_pixel_word;
            r1_mode <= r_view_mode;
            for (int l = 0; l < N_LANE; l++) begin
                r1_sq[l]  <= in_prod[l][SQ_W-1:0];
                r1_neg[l] <= !in_byte[l][7];
            end
        end
    end

    // Stage 2: sum of squares and scaled targets
    always_comb begin
        s_sum = {1'b0, r1_sq[0]} + {1'b0, r1_sq[1]} + {1'b0, r1_sq[2]};
        for (int l = 0; l < N_LANE; l++) begin
            t_prod[l] = {{(T_W + 1 - SQ_W){1'b0}}, r1_sq[l]} * (T_W + 1)'(T_SCALE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en2) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_word <= r1_word;
            r2_mode <= r1_mode;
            r2_s    <= s_sum;
            for (int l = 0; l < N_LANE; l++) begin
                r2_lane[l].q   <= '0;
                r2_lane[l].r   <= -$signed({{(R_W - S_W){1'b0}}, s_sum});
                r2_lane[l].p   <= P_W'(s_sum);
                r2_lane[l].t   <= t_prod[l][T_W-1:0];
                r2_lane[l].neg <= r1_neg[l];
            end
        end
    end

    // Search stages, most significant bit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_STEP; k++) begin
                r_sv_vld[k] <= 1'b0;
            end
        end else begin
            if (en_sv[0]) begin
                r_sv_vld[0] <= r2_vld;
            end
            for (int k = 1; k < N_STEP; k++) begin
                if (en_sv[k]) begin
                    r_sv_vld[k] <= r_sv_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_sv[0]) begin
            r_sv_word[0] <= r2_word;
            r_sv_mode[0] <= r2_mode;
            r_sv_s[0]    <= r2_s;
        end
        for (int k = 1; k < N_STEP; k++) begin
            if (en_sv[k]) begin
                r_sv_word[k] <= r_sv_word[k-1];
                r_sv_mode[k] <= r_sv_mode[k-1];
                r_sv_s[k]    <= r_sv_s[k-1];
            end
        end
    end

    for (genvar l = 0; l < N_LANE; l++) begin : g_lane0
        nmr_search_step #(
            .BIT_IDX (N_STEP - 1)
        ) u_step (
            .i_clk  (i_clk),
            .i_en   (en_sv[0]),
            .i_s    (r2_s),
            .i_lane (r2_lane[l]),
            .o_lane (w_lane[0][l])
        );
    end

    for (genvar k = 1; k < N_STEP; k++) begin : g_step
        for (genvar l = 0; l < N_LANE; l++) begin : g_lane
            nmr_search_step #(
                .BIT_IDX (N_STEP - 1 - k)
            ) u_step (
                .i_clk  (i_clk),
                .i_en   (en_sv[k]),
                .i_s    (r_sv_s[k-1]),
                .i_lane (w_lane[k-1][l]),
                .o_lane (w_lane[k][l])
            );
        end
    end

    // Output stage
    always_comb begin
        case (r_sv_mode[N_STEP-1])
            VIEW_NORMAL: begin
                if (r_sv_s[N_STEP-1] == '0) begin
                    n_out_chan[0] = COMP_BIAS;
                    n_out_chan[1] = COMP_BIAS;
                    n_out_chan[2] = CHAN_MAX;
                end else begin
                    for (int l = 0; l < N_LANE; l++) begin
                        n_out_chan[l] = w_lane[N_STEP-1][l].neg
                            ? COMP_BIAS - {1'b0, w_lane[N_STEP-1][l].q}
                            : COMP_BIAS + {1'b0, w_lane[N_STEP-1][l].q};
                    end
                end
            end
            VIEW_ALPHA: begin
                for (int l = 0; l < N_LANE; l++) begin
                    n_out_chan[l] = r_sv_word[N_STEP-1][31:24];
                end
            end
            default: begin
                for (int l = 0; l < N_LANE; l++) begin
                    n_out_chan[l] = r_sv_word[N_STEP-1][8*(N_LANE-1-l) +: 8];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en_out) begin
            r_out_vld <= r_sv_vld[N_STEP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            for (int l = 0; l < N_LANE; l++) begin
                r_out_chan[l] <= n_out_chan[l];
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_red_out   = r_out_chan[0];
    assign o_green_out = r_out_chan[1];
    assign o_blue_out  = r_out_chan[2];

endmodule

// ===== sv/nmr_search_step.sv =====
// One registered step of the bitwise rounding search for one color component.
`timescale 1ns / 1ps

module nmr_search_step #(
    parameter int BIT_IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [nmr_pkg::S_W-1:0]     i_s,
    input  nmr_pkg::t_lane              i_lane,
    output nmr_pkg::t_lane              o_lane
);
    import nmr_pkg::*;

    localparam logic [Q_W-1:0] Q_BIT = Q_W'(1 << BIT_IDX);

    logic signed [C_W-1:0] cand;
    logic signed [C_W-1:0] t_ext;
    logic signed [R_W-1:0] r_step;
    logic                  hit;
    t_lane                 n_lane;
    t_lane                 r_lane;

    // The candidate is (2q'-1)^2 * S, built from the running (2q-1)^2 * S and (2q-1) * S.
    always_comb begin
        cand = $signed({{(C_W - P_W){1'b0}}, i_lane.p})
             + ($signed({{(C_W - R_W){i_lane.r[R_W-1]}}, i_lane.r}) <<< (BIT_IDX + 2))
             + ($signed({{(C_W - S_W){1'b0}}, i_s}) <<< (2 * BIT_IDX + 2));
        t_ext  = $signed({{(C_W - T_W){1'b0}}, i_lane.t});
        r_step = $signed({{(R_W - S_W){1'b0}}, i_s}) <<< (BIT_IDX + 1);
        hit    = i_lane.neg ? (cand < t_ext) : (cand <= t_ext);
        n_lane = i_lane;
        if (hit) begin
            n_lane.q = i_lane.q | Q_BIT;
            n_lane.p = cand[P_W-1:0];
            n_lane.r = i_lane.r + r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the normal map pixel renormalize block.
`timescale 1ns / 1ps

module testbench;

    import nmr_pkg::*;

    localparam int BIAS = COMP_BIAS;
    localparam int UNIT = UNIT_LEN;
    localparam logic [1:0] VIEW_SPARE = 2'd3;
    localparam int DIR_ROWS = 24;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_WORDS = 92;
    localparam int HOLD_LEN = 200;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [31:0] pixel;
        t_rgb        rgb;
    } t_preview_exp;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] pixel;
        logic        known;
        t_rgb        rgb;
    } t_dir_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pixel_valid = 1'b0;
    logic        pixel_ready;
    logic [31:0] pixel_word = '0;
    logic        rgb_valid;
    logic        rgb_ready = 1'b0;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;

    logic [1:0]   view_copy = VIEW_PLAIN;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;
    int           mismatch_count = 0;
    t_preview_exp pending_rgb[$];

    // Unit vectors along each axis and the zero vector have results that are
    // plain to see; the diagonal and mixed rows go through the predictor.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{VIEW_PLAIN,  32'h0000_0000, 1'b1, 24'h000000},
        '{VIEW_PLAIN,  32'hFFFF_FFFF, 1'b1, 24'hFFFFFF},
        '{VIEW_PLAIN,  32'h5A12_3456, 1'b1, 24'h123456},
        '{VIEW_PLAIN,  32'h00FF_0080, 1'b1, 24'hFF0080},
        '{VIEW_ALPHA,  32'hFF00_0000, 1'b1, 24'hFFFFFF},
        '{VIEW_ALPHA,  32'h00FF_FFFF, 1'b1, 24'h000000},
        '{VIEW_ALPHA,  32'h7E12_3456, 1'b1, 24'h7E7E7E},
        '{VIEW_NORMAL, 32'h0080_8080, 1'b1, 24'h8080FF},
        '{VIEW_NORMAL, 32'hFF80_8080, 1'b1, 24'h8080FF},
        '{VIEW_NORMAL, 32'h00FF_8080, 1'b1, 24'hFF8080},
        '{VIEW_NORMAL, 32'h0000_8080, 1'b1, 24'h018080},
        '{VIEW_NORMAL, 32'h0080_FF80, 1'b1, 24'h80FF80},
        '{VIEW_NORMAL, 32'h0080_0080, 1'b1, 24'h800180},
        '{VIEW_NORMAL, 32'h0080_80FF, 1'b1, 24'h8080FF},
        '{VIEW_NORMAL, 32'h0080_8000, 1'b1, 24'h808001},
        '{VIEW_NORMAL, 32'h0081_8080, 1'b1, 24'hFF8080},
        '{VIEW_NORMAL, 32'h007F_8080, 1'b1, 24'h018080},
        '{VIEW_NORMAL, 32'h0000_0000, 1'b0, 24'h000000},
        '{VIEW_NORMAL, 32'hFFFF_FFFF, 1'b0, 24'h000000},
        '{VIEW_NORMAL, 32'h0081_7F80, 1'b0, 24'h000000},
        '{VIEW_NORMAL, 32'h00FF_0000, 1'b0, 24'h000000},
        '{VIEW_NORMAL, 32'h3C80_7F81, 1'b0, 24'h000000},
        '{VIEW_SPARE,  32'hFF12_3456, 1'b1, 24'h123456},
        '{VIEW_SPARE,  32'h00FF_FFFF, 1'b1, 24'hFFFFFF}
    };

    normal_map_pixel_renormalize_top u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (pixel_valid),
        .o_ready      (pixel_ready),
        .i_pixel_word (pixel_word),
        .o_valid      (rgb_valid),
        .i_ready      (rgb_ready),
        .o_red_out    (red_out),
        .o_green_out  (green_out),
        .o_blue_out   (blue_out),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    // The rounding of 127*c/sqrt(S) + 1/2 is settled by comparing squares in integers.
    function automatic logic [7:0] renorm_component(int comp, longint unsigned sumsq);
        longint unsigned mag;
        longint unsigned target;
        longint unsigned odd;
        int              steps;
        mag = (comp < 0) ? -comp : comp;
        target = (2 * UNIT * mag) * (2 * UNIT * mag);
        steps = 0;
        if (comp >= 0) begin
            while (steps < UNIT) begin
                odd = 2 * steps + 1;
                if (odd * odd * sumsq <= target) steps++;
                else break;
            end
            return 8'(BIAS + steps);
        end
        while (steps < BIAS) begin
            odd = 2 * steps + 1;
            if (odd * odd * sumsq >= target) break;
            steps++;
        end
        return 8'(BIAS - steps);
    endfunction

    function automatic t_rgb predict_preview(logic [1:0] mode, logic [31:0] pixel);
        t_rgb            res;
        int              cr;
        int              cg;
        int              cb;
        longint unsigned sumsq;
        res = pixel[23:0];
        cr = int'(pixel[23:16]) - BIAS;
        cg = int'(pixel[15:8]) - BIAS;
        cb = int'(pixel[7:0]) - BIAS;
        case (mode)
            VIEW_NORMAL: begin
                sumsq = cr * cr + cg * cg + cb * cb;
                if (sumsq == 0) begin
                    res = {8'(BIAS), 8'(BIAS), 8'(BIAS + UNIT)};
                end else begin
                    res.red   = renorm_component(cr, sumsq);
                    res.green = renorm_component(cg, sumsq);
                    res.blue  = renorm_component(cb, sumsq);
                end
            end
            VIEW_ALPHA: res = {3{pixel[31:24]}};
            default: res = pixel[23:0];
        endcase
        return res;
    endfunction

    function automatic logic [7:0] edge_byte();
        case ($urandom_range(0, 6))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h7F;
            3: return 8'h80;
            4: return 8'h81;
            5: return 8'hFE;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic logic [7:0] near_bias_byte();
        return 8'(BIAS + int'($urandom_range(0, 6)) - 3);
    endfunction

    // Normal view gets full-range vectors, near-zero vectors, edge values and
    // vectors dominated by one axis.
    function automatic logic [31:0] random_pixel(logic [1:0] mode);
        logic [31:0] px;
        int          kind;
        px = $urandom;
        kind = $urandom_range(0, 99);
        if (mode == VIEW_NORMAL) begin
            if (kind >= 85) begin
                px[23:0] = {near_bias_byte(), near_bias_byte(), near_bias_byte()};
                case ($urandom_range(0, 2))
                    0: px[23:16] = edge_byte();
                    1: px[15:8]  = edge_byte();
                    default: px[7:0] = edge_byte();
                endcase
            end else if (kind >= 70) begin
                px[23:0] = {edge_byte(), edge_byte(), edge_byte()};
            end else if (kind >= 55) begin
                px[23:0] = {near_bias_byte(), near_bias_byte(), near_bias_byte()};
            end
        end
        return px;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t ns] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic offer_pixel(logic [31:0] px, logic known, t_rgb known_rgb);
        t_preview_exp entry;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_word <= px;
        do @(posedge clk); while (!pixel_ready);
        entry.pixel = px;
        entry.rgb = known ? known_rgb : predict_preview(view_copy, px);
        pending_rgb.push_back(entry);
    endtask

    task automatic drain_results();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_rgb.size() != 0) @(posedge clk);
    endtask

    task automatic set_view_mode(logic [1:0] mode);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        view_copy = mode;
    endtask

    task automatic check_preview();
        t_preview_exp want;
        t_rgb         seen;
        seen = {red_out, green_out, blue_out};
        if (pending_rgb.size() == 0) begin
            report_mismatch($sformatf("result %06h with no pixel pending", seen));
            return;
        end
        want = pending_rgb.pop_front();
        if (seen.red !== want.rgb.red)
            report_mismatch($sformatf("pixel %08h red_out %02h, expected %02h",
                want.pixel, seen.red, want.rgb.red));
        if (seen.green !== want.rgb.green)
            report_mismatch($sformatf("pixel %08h green_out %02h, expected %02h",
                want.pixel, seen.green, want.rgb.green));
        if (seen.blue !== want.rgb.blue)
            report_mismatch($sformatf("pixel %08h blue_out %02h, expected %02h",
                want.pixel, seen.blue, want.rgb.blue));
    endtask

    always @(posedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_LEN;
            rgb_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rgb_ready <= 1'b0;
        end else begin
            rgb_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && rgb_valid && rgb_ready) check_preview();
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((pixel_valid && pixel_ready) || (rgb_valid && rgb_ready)
                    || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int         phase;
        int         n;
        logic [1:0] mode;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIR_ROWS; n++) begin
            if (dir_rows[n].mode != view_copy) set_view_mode(dir_rows[n].mode);
            offer_pixel(dir_rows[n].pixel, dir_rows[n].known, dir_rows[n].rgb);
        end

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase % 6)
                1: mode = VIEW_PLAIN;
                3: mode = VIEW_ALPHA;
                5: mode = VIEW_SPARE;
                default: mode = VIEW_NORMAL;
            endcase
            set_view_mode(mode);
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase
            // The output side holds off here while words keep coming, so the
            // pipeline fills and backs up into the input.
            if (phase == 4) hold_requests++;
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (phase == 7 && n == PHASE_WORDS / 2) drain_results();
                offer_pixel(random_pixel(view_copy), 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
